>>> src/isst_pkg.sv
package isst_pkg;

    // field and counter widths
    localparam int MIN_W   = 6;
    localparam int IDLE_W  = 16;
    localparam int COUNT_W = 13;
    localparam int DIV_W   = 8;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 2;
    localparam int DATA_W  = 16;

    // timing constants, in ticks
    localparam int TICKS_PER_MINUTE = 120;
    localparam int BLINK_TICKS      = 2;
    localparam int POLL_TICKS       = 4;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [INDEX_W-1:0] cfg_index_t;
    typedef logic [DATA_W-1:0]  cfg_data_t;

    // item kinds
    localparam kind_t KIND_TICK = 2'd0;
    localparam kind_t KIND_KEY  = 2'd1;
    localparam kind_t KIND_ACK  = 2'd2;

    // register indexes
    localparam cfg_index_t CFG_AUTO_STANDBY = 2'd0;
    localparam cfg_index_t CFG_SLEEP        = 2'd1;
    localparam cfg_index_t CFG_IDLE_TIMEOUT = 2'd2;

    // reset value of the idle timeout
    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RESET = 16'd20;

endpackage

>>> src/isst_item_if.sv
interface isst_item_if
    import isst_pkg::*;
;
    logic  valid;
    logic  ready;
    kind_t kind;
    logic  standby;
    logic  mute;

    modport source (output valid, output kind, output standby, output mute, input ready);
    modport sink   (input valid, input kind, input standby, input mute, output ready);
endinterface

>>> src/isst_result_if.sv
interface isst_result_if;
    logic valid;
    logic ready;
    logic auto_standby_request;
    logic sleep_active;
    logic sleep_entered;
    logic idle_active;
    logic blink_phase;
    logic sensor_poll;

    modport source (
        output valid, output auto_standby_request, output sleep_active,
        output sleep_entered, output idle_active, output blink_phase,
        output sensor_poll, input ready
    );
    modport sink (
        input valid, input auto_standby_request, input sleep_active,
        input sleep_entered, input idle_active, input blink_phase,
        input sensor_poll, output ready
    );
endinterface

>>> src/isst_cfg_if.sv
interface isst_cfg_if
    import isst_pkg::*;
;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/inactivity_standby_sleep_timers.sv
// Inactivity, standby and sleep timers. Every input beat (tick, key or auto
// standby acknowledge, with the present standby and mute levels) produces
// exactly one result beat with the auto standby request, sleep and idle
// flags, the sleep entry pulse, the blink phase and the sensor poll pulse.
// Throughput is one beat per clock unless results stall; the result
// register is loaded in the same edge that takes the input beat and updates
// the timer state. The input side is ready whenever that register is empty
// or its beat is taken in the same cycle. Timer targets are minutes times
// 120 ticks; a zero minute setting disables that timer. Configuration
// writes are always accepted and take effect for the next input beat.
module inactivity_standby_sleep_timers
    import isst_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    isst_cfg_if.sink      cfg,
    isst_item_if.sink     item,
    isst_result_if.source result
);

    // configuration registers
    logic [MIN_W-1:0]   auto_min_reg;
    logic [MIN_W-1:0]   sleep_min_reg;
    logic [IDLE_W-1:0]  idle_timeout_reg;

    // timer state
    logic [COUNT_W-1:0] auto_count_reg,  auto_count_next;
    logic               auto_flag_reg,   auto_flag_next;
    logic [COUNT_W-1:0] sleep_count_reg, sleep_count_next;
    logic               sleep_state_reg, sleep_state_next;
    logic [IDLE_W-1:0]  idle_count_reg,  idle_count_next;
    logic               idle_state_reg,  idle_state_next;
    logic [DIV_W-1:0]   blink_count_reg, blink_count_next;
    logic               blink_state_reg, blink_state_next;
    logic [DIV_W-1:0]   poll_count_reg,  poll_count_next;

    // result register
    logic               res_valid_reg;
    logic               res_entered_reg, res_entered_next;
    logic               res_poll_reg,    res_poll_next;

    logic               item_accept;
    logic [COUNT_W-1:0] auto_target;
    logic [COUNT_W-1:0] sleep_target;

    assign cfg.ready   = 1'b1;
    assign item.ready  = !res_valid_reg || result.ready;
    assign item_accept = item.valid && item.ready;

    // minute targets in ticks
    assign auto_target  = COUNT_W'(auto_min_reg)  * COUNT_W'(TICKS_PER_MINUTE);
    assign sleep_target = COUNT_W'(sleep_min_reg) * COUNT_W'(TICKS_PER_MINUTE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_min_reg     <= '0;
            sleep_min_reg    <= '0;
            idle_timeout_reg <= IDLE_TIMEOUT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_AUTO_STANDBY: auto_min_reg     <= cfg.data[MIN_W-1:0];
                CFG_SLEEP:        sleep_min_reg    <= cfg.data[MIN_W-1:0];
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg.data[IDLE_W-1:0];
                default:          ;
            endcase
        end
    end

    // timer update for one beat
    always_comb
    begin
        auto_count_next  = auto_count_reg;
        auto_flag_next   = auto_flag_reg;
        sleep_count_next = sleep_count_reg;
        sleep_state_next = sleep_state_reg;
        idle_count_next  = idle_count_reg;
        idle_state_next  = idle_state_reg;
        blink_count_next = blink_count_reg;
        blink_state_next = blink_state_reg;
        poll_count_next  = poll_count_reg;
        res_entered_next = 1'b0;
        res_poll_next    = 1'b0;

        unique case (item.kind)
            KIND_TICK:
            begin
                // auto standby timer, paused in standby and while requested
                if (!auto_flag_reg && auto_min_reg != '0 && !item.standby)
                begin
                    auto_count_next = auto_count_reg + 1'b1;
                    if (auto_count_next >= auto_target)
                    begin
                        auto_flag_next   = 1'b1;
                        auto_count_next  = '0;
                        sleep_state_next = 1'b0;
                        sleep_count_next = '0;
                        idle_state_next  = 1'b0;
                        idle_count_next  = '0;
                    end
                end
                // idle timeout
                if (!idle_state_next)
                begin
                    idle_count_next = idle_count_next + 1'b1;
                    if (idle_count_next >= idle_timeout_reg)
                    begin
                        idle_state_next = 1'b1;
                        idle_count_next = '0;
                    end
                end
                // sleep timer
                if (!sleep_state_next && sleep_min_reg != '0 && !item.standby)
                begin
                    sleep_count_next = sleep_count_next + 1'b1;
                    if (sleep_count_next >= sleep_target)
                    begin
                        sleep_state_next = 1'b1;
                        sleep_count_next = '0;
                        res_entered_next = 1'b1;
                    end
                end
                // blink divider
                blink_count_next = blink_count_reg + 1'b1;
                if (blink_count_next >= DIV_W'(BLINK_TICKS))
                begin
                    blink_state_next = !blink_state_reg;
                    blink_count_next = '0;
                end
                // sensor poll divider
                poll_count_next = poll_count_reg + 1'b1;
                if (poll_count_next >= DIV_W'(POLL_TICKS))
                begin
                    poll_count_next = '0;
                    res_poll_next   = 1'b1;
                end
            end
            KIND_KEY:
            begin
                sleep_state_next = 1'b0;
                sleep_count_next = '0;
                idle_state_next  = 1'b0;
                idle_count_next  = '0;
            end
            KIND_ACK:
            begin
                auto_flag_next = 1'b0;
            end
            default: ;
        endcase

        // hold rules for standby, mute and sleep
        if (item.standby)
        begin
            sleep_state_next = 1'b0;
        end
        if (item.standby || item.mute || sleep_state_next)
        begin
            idle_count_next  = '0;
            idle_state_next  = 1'b0;
            sleep_count_next = '0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_count_reg  <= '0;
            auto_flag_reg   <= 1'b0;
            sleep_count_reg <= '0;
            sleep_state_reg <= 1'b0;
            idle_count_reg  <= '0;
            idle_state_reg  <= 1'b0;
            blink_count_reg <= '0;
            blink_state_reg <= 1'b0;
            poll_count_reg  <= '0;
        end
        else if (item_accept)
        begin
            auto_count_reg  <= auto_count_next;
            auto_flag_reg   <= auto_flag_next;
            sleep_count_reg <= sleep_count_next;
            sleep_state_reg <= sleep_state_next;
            idle_count_reg  <= idle_count_next;
            idle_state_reg  <= idle_state_next;
            blink_count_reg <= blink_count_next;
            blink_state_reg <= blink_state_next;
            poll_count_reg  <= poll_count_next;
        end
    end

    // result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result pulses
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            res_entered_reg <= res_entered_next;
            res_poll_reg    <= res_poll_next;
        end
    end

    // flags come straight from the state, which only moves with a new beat
    assign result.valid                = res_valid_reg;
    assign result.auto_standby_request = auto_flag_reg;
    assign result.sleep_active         = sleep_state_reg;
    assign result.sleep_entered        = res_entered_reg;
    assign result.idle_active          = idle_state_reg;
    assign result.blink_phase          = blink_state_reg;
    assign result.sensor_poll          = res_poll_reg;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import isst_pkg::*;

    // kind and register index codes the block has no use for
    localparam kind_t      KIND_SPARE = 2'd3;
    localparam cfg_index_t CFG_SPARE  = 2'd3;

    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 40;

    typedef struct packed {
        logic auto_req;
        logic sleep_on;
        logic sleep_entry;
        logic idle_on;
        logic blink;
        logic poll;
    } timer_flags_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    // tracks the timers and holds the flags each result beat must carry
    class timer_flag_board;
        logic [MIN_W-1:0]   auto_minutes;
        logic [MIN_W-1:0]   sleep_minutes;
        logic [IDLE_W-1:0]  idle_limit;
        logic [COUNT_W-1:0] auto_count;
        logic [COUNT_W-1:0] sleep_count;
        logic [IDLE_W-1:0]  idle_count;
        logic [DIV_W-1:0]   blink_count;
        logic [DIV_W-1:0]   poll_count;
        logic               auto_flag;
        logic               asleep;
        logic               idle_flag;
        logic               blink_flag;
        timer_flags_t       pending_flags[$];
        int                 errors;
        int                 beats_in;
        int                 beats_out;
        int                 auto_requests;
        int                 sleep_entries;
        int                 idle_rises;
        int                 polls;

        function new();
            auto_minutes  = '0;
            sleep_minutes = '0;
            idle_limit    = IDLE_TIMEOUT_RESET;
            auto_count    = '0;
            sleep_count   = '0;
            idle_count    = '0;
            blink_count   = '0;
            poll_count    = '0;
            auto_flag     = 1'b0;
            asleep        = 1'b0;
            idle_flag     = 1'b0;
            blink_flag    = 1'b0;
            errors        = 0;
            beats_in      = 0;
            beats_out     = 0;
            auto_requests = 0;
            sleep_entries = 0;
            idle_rises    = 0;
            polls         = 0;
        endfunction

        function void write_register(cfg_index_t index, cfg_data_t data);
            case (index)
                CFG_AUTO_STANDBY: auto_minutes = data[MIN_W-1:0];
                CFG_SLEEP:        sleep_minutes = data[MIN_W-1:0];
                CFG_IDLE_TIMEOUT: idle_limit = data[IDLE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(kind_t kind, logic stby, logic mute);
            timer_flags_t exp_flags;
            logic         entered;
            logic         poll;
            logic         was_auto;
            logic         was_idle;
            entered  = 1'b0;
            poll     = 1'b0;
            was_auto = auto_flag;
            was_idle = idle_flag;
            beats_in++;
            case (kind)
                KIND_TICK:
                begin
                    // auto standby, paused in standby and while a request waits
                    if (!auto_flag && auto_minutes != 0 && !stby)
                    begin
                        auto_count = auto_count + 1'b1;
                        if (int'(auto_count) >= int'(auto_minutes) * TICKS_PER_MINUTE)
                        begin
                            auto_flag   = 1'b1;
                            auto_count  = '0;
                            asleep      = 1'b0;
                            sleep_count = '0;
                            idle_flag   = 1'b0;
                            idle_count  = '0;
                        end
                    end
                    // idle timeout
                    if (!idle_flag)
                    begin
                        idle_count = idle_count + 1'b1;
                        if (idle_count >= idle_limit)
                        begin
                            idle_flag  = 1'b1;
                            idle_count = '0;
                        end
                    end
                    // sleep timer
                    if (!asleep && sleep_minutes != 0 && !stby)
                    begin
                        sleep_count = sleep_count + 1'b1;
                        if (int'(sleep_count) >= int'(sleep_minutes) * TICKS_PER_MINUTE)
                        begin
                            asleep      = 1'b1;
                            sleep_count = '0;
                            entered     = 1'b1;
                        end
                    end
                    // blink and poll dividers
                    blink_count = blink_count + 1'b1;
                    if (int'(blink_count) >= BLINK_TICKS)
                    begin
                        blink_flag  = !blink_flag;
                        blink_count = '0;
                    end
                    poll_count = poll_count + 1'b1;
                    if (int'(poll_count) >= POLL_TICKS)
                    begin
                        poll_count = '0;
                        poll       = 1'b1;
                    end
                end
                KIND_KEY:
                begin
                    asleep      = 1'b0;
                    sleep_count = '0;
                    idle_flag   = 1'b0;
                    idle_count  = '0;
                end
                KIND_ACK: auto_flag = 1'b0;
                default: ;
            endcase
            // hold rules after every beat
            if (stby)
                asleep = 1'b0;
            if (stby || mute || asleep)
            begin
                idle_count  = '0;
                idle_flag   = 1'b0;
                sleep_count = '0;
            end
            if (auto_flag && !was_auto)
                auto_requests++;
            if (idle_flag && !was_idle)
                idle_rises++;
            if (entered)
                sleep_entries++;
            if (poll)
                polls++;
            exp_flags = '{auto_req: auto_flag, sleep_on: asleep, sleep_entry: entered,
                          idle_on: idle_flag, blink: blink_flag, poll: poll};
            pending_flags.push_back(exp_flags);
        endfunction

        function int pending();
            return pending_flags.size();
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task compare_bit(string field, logic got, logic exp);
            if (got !== exp)
                report($sformatf("result beat %0d %s got %b expected %b",
                                 beats_out, field, got, exp));
        endtask

        task check_flags(timer_flags_t got);
            timer_flags_t exp;
            beats_out++;
            if (pending_flags.size() == 0)
            begin
                report($sformatf("result beat %0d with no item waiting", beats_out));
                return;
            end
            exp = pending_flags.pop_front();
            compare_bit("auto_standby_request", got.auto_req, exp.auto_req);
            compare_bit("sleep_active", got.sleep_on, exp.sleep_on);
            compare_bit("sleep_entered", got.sleep_entry, exp.sleep_entry);
            compare_bit("idle_active", got.idle_on, exp.idle_on);
            compare_bit("blink_phase", got.blink, exp.blink);
            compare_bit("sensor_poll", got.poll, exp.poll);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    isst_cfg_if    cfg_ch();
    isst_item_if   item_ch();
    isst_result_if result_ch();

    timer_flag_board flags_board;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;

    inactivity_standby_sleep_timers u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task set_idling(idling_t mode);
        send_idle_pct  = (mode == IDLE_SENDER) ? 56 : (mode == IDLE_BOTH) ? 13 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 56 : (mode == IDLE_BOTH) ? 13 : 0;
    endtask

    // offer one input beat, starting and ending at a falling edge
    task send_beat(kind_t kind, logic stby, logic mute);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid   = 1'b1;
        item_ch.kind    = kind;
        item_ch.standby = stby;
        item_ch.mute    = mute;
        do
            @(posedge clk);
        while (!item_ch.ready);
        flags_board.note_item(kind, stby, mute);
        @(negedge clk);
    endtask

    task write_reg(cfg_index_t index, cfg_data_t data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        flags_board.write_register(index, data);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // wait until every result is back and the block has settled
    task drain();
        item_ch.valid = 1'b0;
        while (flags_board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // mostly plain ticks; noise_pct of the beats get a random kind and levels
    task run_items(int count, int noise_pct);
        kind_t kind;
        logic  stby;
        logic  mute;
        for (int n = 0; n < count; n++)
        begin
            kind = KIND_TICK;
            stby = 1'b0;
            mute = 1'b0;
            if ($urandom_range(99) < noise_pct)
            begin
                kind = kind_t'($urandom_range(3));
                stby = ($urandom_range(3) == 0);
                mute = ($urandom_range(3) == 0);
            end
            send_beat(kind, stby, mute);
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int           hold_left;
        timer_flags_t got;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready = 1'b0;
                hold_left--;
            end
            else
                result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got = '{auto_req: result_ch.auto_standby_request,
                        sleep_on: result_ch.sleep_active,
                        sleep_entry: result_ch.sleep_entered,
                        idle_on: result_ch.idle_active,
                        blink: result_ch.blink_phase,
                        poll: result_ch.sensor_poll};
                flags_board.check_flags(got);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no beat for %0d cycles", STALL_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        flags_board     = new();
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.kind    = KIND_TICK;
        item_ch.standby = 1'b0;
        item_ch.mute    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_AUTO_STANDBY;
        cfg_ch.data     = '0;
        set_idling(IDLE_NONE);
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // every kind against the standby and mute levels, default settings
        send_beat(KIND_TICK, 1'b0, 1'b0);
        send_beat(KIND_TICK, 1'b1, 1'b0);
        send_beat(KIND_TICK, 1'b0, 1'b1);
        send_beat(KIND_TICK, 1'b1, 1'b1);
        send_beat(KIND_KEY, 1'b0, 1'b0);
        send_beat(KIND_ACK, 1'b0, 1'b0);
        send_beat(KIND_SPARE, 1'b0, 1'b0);
        send_beat(KIND_KEY, 1'b1, 1'b0);
        send_beat(KIND_ACK, 1'b0, 1'b1);
        send_beat(KIND_SPARE, 1'b1, 1'b1);
        send_beat(KIND_TICK, 1'b0, 1'b0);
        drain();

        // zero idle timeout rises on the next counted tick
        write_reg(CFG_IDLE_TIMEOUT, '0);
        send_beat(KIND_TICK, 1'b0, 1'b0);
        send_beat(KIND_TICK, 1'b0, 1'b0);
        send_beat(KIND_KEY, 1'b0, 1'b0);
        send_beat(KIND_TICK, 1'b0, 1'b0);
        send_beat(KIND_SPARE, 1'b0, 1'b0);
        drain();

        // a clean tick run, then one with 3 percent noise: sleep after one minute, auto standby after two
        write_reg(CFG_AUTO_STANDBY, 16'd2);
        write_reg(CFG_SLEEP, 16'd1);
        write_reg(CFG_IDLE_TIMEOUT, 16'd5);
        run_items(130, 0);
        run_items(130, 3);
        drain();

        // largest targets, counts left running for the next phases
        set_idling(IDLE_SENDER);
        write_reg(CFG_AUTO_STANDBY, 16'd63);
        write_reg(CFG_SLEEP, 16'd63);
        write_reg(CFG_IDLE_TIMEOUT, 16'hFFFF);
        run_items(130, 0);
        drain();

        // sleep target lowered below its count, auto disabled with junk upper bits
        set_idling(IDLE_RECEIVER);
        write_reg(CFG_AUTO_STANDBY, 16'hFFC0);
        write_reg(CFG_SLEEP, 16'd1);
        write_reg(CFG_IDLE_TIMEOUT, 16'd1);
        send_beat(KIND_TICK, 1'b0, 1'b0);
        run_items(60, 10);
        drain();

        // auto target lowered below its held count, then pure noise
        set_idling(IDLE_BOTH);
        write_reg(CFG_AUTO_STANDBY, 16'd1);
        write_reg(CFG_SLEEP, 16'd0);
        write_reg(CFG_IDLE_TIMEOUT, 16'd3);
        write_reg(CFG_SPARE, 16'hA5A5);
        run_items(60, 100);
        drain();

        // random settings with a long result hold-off up front
        set_idling(IDLE_RECEIVER);
        write_reg(CFG_AUTO_STANDBY, cfg_data_t'($urandom_range(1, 2)));
        write_reg(CFG_SLEEP, 16'd1);
        write_reg(CFG_IDLE_TIMEOUT, cfg_data_t'($urandom_range(1, 40)));
        hold_request = 1'b1;
        run_items(100, 5);
        drain();

        $display("covered %0d input beats and %0d result beats across seven settings",
                 flags_board.beats_in, flags_board.beats_out);
        $display("auto standby requests %0d, sleep entries %0d, idle rises %0d, polls %0d",
                 flags_board.auto_requests, flags_board.sleep_entries,
                 flags_board.idle_rises, flags_board.polls);
        if (flags_board.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
